### sv/zalhc_pkg.sv
package zalhc_pkg;

  localparam int NUM_LEDS   = 3;
  localparam int NUM_ZONES  = 4;
  localparam int MAX_MSG    = 6;
  localparam int CNT_W      = $clog2(MAX_MSG + 1);
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int SECONDS_W  = 32;
  localparam int ZONE_W     = 2;
  localparam int LED_IDX_W  = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  // Item kinds carried in in_tuser.
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_REFRESH = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CONCERN_HOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_HOLD   = 1'b1;

  // Zone status codes; the unused code reads as no detection.
  localparam logic [ZONE_W-1:0] ZS_NONE     = 2'd0;
  localparam logic [ZONE_W-1:0] ZS_POSSIBLE = 2'd1;
  localparam logic [ZONE_W-1:0] ZS_DETECT   = 2'd2;

  typedef enum logic [1:0] {
    LVL_IDLE    = 2'd0,
    LVL_CONCERN = 2'd1,
    LVL_ALARM   = 2'd2
  } level_t;

  typedef struct packed {
    logic [LED_IDX_W-1:0] led_index;
    level_t               level;
    logic                 notify;
  } msg_t;

  // Wanted LED levels per zone for a possible and for a confirmed detection.
  localparam level_t ROW_POSSIBLE [NUM_ZONES][NUM_LEDS] = '{
    '{LVL_ALARM,   LVL_CONCERN, LVL_IDLE},
    '{LVL_ALARM,   LVL_ALARM,   LVL_CONCERN},
    '{LVL_CONCERN, LVL_IDLE,    LVL_IDLE},
    '{LVL_ALARM,   LVL_CONCERN, LVL_IDLE}
  };

  localparam level_t ROW_DETECT [NUM_ZONES][NUM_LEDS] = '{
    '{LVL_ALARM, LVL_ALARM,   LVL_CONCERN},
    '{LVL_ALARM, LVL_ALARM,   LVL_ALARM},
    '{LVL_ALARM, LVL_CONCERN, LVL_IDLE},
    '{LVL_ALARM, LVL_ALARM,   LVL_CONCERN}
  };

  function automatic level_t zone_want(input int unsigned zone,
                                       input logic [ZONE_W-1:0] status,
                                       input int unsigned led);
    level_t lv;
    lv = LVL_IDLE;
    unique case (status)
      ZS_POSSIBLE: lv = ROW_POSSIBLE[zone][led];
      ZS_DETECT:   lv = ROW_DETECT[zone][led];
      default:     lv = LVL_IDLE;
    endcase
    return lv;
  endfunction

  // Higher level wins; two concerns together make an alarm.
  function automatic level_t merge_level(input level_t cur, input level_t want);
    level_t lv;
    if (cur == LVL_CONCERN && want == LVL_CONCERN) begin
      lv = LVL_ALARM;
    end else if (want > cur) begin
      lv = want;
    end else begin
      lv = cur;
    end
    return lv;
  endfunction

endpackage

### sv/zone_alarm_led_hold_controller.sv
// Zone alarm LED hold controller.
// The input channel (in_*) takes one transaction per event: in_tuser low is a
// one-second tick carrying the seconds value and four zone statuses in
// in_tdata, in_tuser high is a refresh that re-sends all three LED levels.
// Each result transaction on out_* is one message to an LED node: index and
// level in out_tdata, the monitor flag in out_tuser, and out_tlast on the
// final message caused by an input. A tick that changes nothing and falls
// outside the reinforcement period produces no transaction at all.
// The cfg_* channel writes the two hold times and is always ready; the user
// writes it only while the block is idle, which the block itself does not enforce.
//
// The first message of an item passes through the input register, the
// reciprocal multiply, the remainder check, the message buffer and the output
// register. The block then delivers one message per cycle while the receiver
// is ready, up to six per item; the buffer takes the next item as its last one leaves.
// Three earlier pipeline stages keep accepting while the buffer drains.
// When the receiver stalls, the output register holds its transaction, the
// buffer and pipeline fill, and in_tready falls once all stages are full.
// Synchronous reset clears all levels to idle, stops all holds and loads the
// default hold times of 5 and 10 seconds.
module zone_alarm_led_hold_controller #(
  parameter int HOLD_COUNT_WIDTH = 16,
  parameter int REINFORCE_PERIOD = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // seconds[31:0], zone_top_left[33:32], zone_top_right[35:34],
  // zone_bottom_left[37:36], zone_bottom_right[39:38]
  input  logic [zalhc_pkg::IN_DATA_W-1:0]     in_tdata,
  // opcode
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // led_index[1:0], led_level[3:2], zero[7:4]
  output logic [zalhc_pkg::OUT_DATA_W-1:0]    out_tdata,
  // notify_monitor
  output logic                                out_tuser,
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [zalhc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [zalhc_pkg::CFG_W-1:0]         cfg_data
);
  import zalhc_pkg::*;

  // Remainder by the period: the quotient from a truncated reciprocal is at
  // most two short, so the partial remainder is 0, P or 2P exactly when the
  // seconds value is a multiple of P.
  localparam int PERIOD_W = $clog2(REINFORCE_PERIOD + 1);
  localparam int PROD_W   = 2 * SECONDS_W;
  localparam int QP_W     = SECONDS_W + PERIOD_W;
  localparam logic [SECONDS_W-1:0] RECIP =
    SECONDS_W'(64'hFFFF_FFFF / REINFORCE_PERIOD);
  localparam logic [PERIOD_W-1:0]  PERIOD_C  = PERIOD_W'(REINFORCE_PERIOD);
  localparam logic [SECONDS_W-1:0] PERIOD_X1 = SECONDS_W'(REINFORCE_PERIOD);
  localparam logic [SECONDS_W-1:0] PERIOD_X2 = SECONDS_W'(2 * REINFORCE_PERIOD);
  localparam int CMP_W = (HOLD_COUNT_WIDTH > CFG_W) ? HOLD_COUNT_WIDTH : CFG_W;

  typedef logic [HOLD_COUNT_WIDTH-1:0] count_t;

  // Configuration.
  logic [CFG_W-1:0] concern_hold_r;
  logic [CFG_W-1:0] alarm_hold_r;

  // Stage 1: input register.
  logic                  s1_valid_r;
  logic                  s1_op_r;
  logic [SECONDS_W-1:0]  s1_secs_r;
  logic [ZONE_W-1:0]     s1_zone_r [NUM_ZONES];
  level_t                s1_want [NUM_LEDS];
  logic [PROD_W-1:0]     s1_prod;

  // Stage 2: wanted levels and approximate quotient.
  logic                  s2_valid_r;
  logic                  s2_op_r;
  logic [SECONDS_W-1:0]  s2_secs_r;
  logic [SECONDS_W-1:0]  s2_quot_r;
  level_t                s2_want_r [NUM_LEDS];
  logic [QP_W-1:0]       s2_qp;
  logic [SECONDS_W-1:0]  s2_rem;
  logic                  s2_reinf;

  // Stage 3: LED state update and message list.
  logic                  s3_valid_r;
  logic                  s3_op_r;
  logic                  s3_reinf_r;
  level_t                s3_want_r [NUM_LEDS];

  // Per-LED state.
  level_t                shown_r   [NUM_LEDS];
  logic                  running_r [NUM_LEDS];
  count_t                count_r   [NUM_LEDS];
  level_t                shown_nxt   [NUM_LEDS];
  logic                  running_nxt [NUM_LEDS];
  count_t                count_nxt   [NUM_LEDS];
  count_t                count_sat   [NUM_LEDS];
  logic                  expired     [NUM_LEDS];
  logic                  changed     [NUM_LEDS];

  msg_t                  msgs [MAX_MSG];
  logic [CNT_W-1:0]      nmsg;

  // Message buffer, drained one entry per cycle from the front while the output register can take it.
  msg_t                  buf_msg_r [MAX_MSG];
  logic [CNT_W-1:0]      buf_cnt_r;

  // Output register.
  logic                  out_tvalid_r;
  msg_t                  out_msg_r;
  logic                  out_last_r;

  logic out_fire_ok;
  logic buf_emit;
  logic buf_free;
  logic s3_adv;
  logic s3_ready;
  logic s2_ready;
  logic s1_ready;

  // Handshake chain: each stage moves when the one after it can take it.
  assign out_fire_ok = !out_tvalid_r || out_tready;
  assign buf_emit    = out_fire_ok && (buf_cnt_r != '0);
  assign buf_free    = (buf_cnt_r == '0) ||
                       (out_fire_ok && buf_cnt_r == CNT_W'(1));
  assign s3_adv      = s3_valid_r && buf_free;
  assign s3_ready    = !s3_valid_r || buf_free;
  assign s2_ready    = !s2_valid_r || s3_ready;
  assign s1_ready    = !s1_valid_r || s2_ready;
  assign in_tready   = s1_ready;
  assign cfg_ready   = 1'b1;

  // Stage 1 logic: table lookup and merge, then the reciprocal product.
  always_comb begin
    for (int i = 0; i < NUM_LEDS; i++) begin
      s1_want[i] = LVL_IDLE;
      for (int z = 0; z < NUM_ZONES; z++) begin
        s1_want[i] = merge_level(s1_want[i], zone_want(z, s1_zone_r[z], i));
      end
    end
  end

  assign s1_prod = PROD_W'(s1_secs_r) * PROD_W'(RECIP);

  // Stage 2 logic: partial remainder and multiple-of-period test.
  assign s2_qp    = QP_W'(s2_quot_r) * QP_W'(PERIOD_C);
  assign s2_rem   = s2_secs_r - s2_qp[SECONDS_W-1:0];
  assign s2_reinf = (s2_rem == '0) || (s2_rem == PERIOD_X1) || (s2_rem == PERIOD_X2);

  // Stage 3 logic: hold expiry and the next LED state.
  always_comb begin
    for (int i = 0; i < NUM_LEDS; i++) begin
      count_sat[i] = (count_r[i] == '1) ? count_r[i] : count_r[i] + count_t'(1);
      expired[i]   = (shown_r[i] == LVL_CONCERN &&
                      CMP_W'(count_r[i]) >= CMP_W'(concern_hold_r)) ||
                     (shown_r[i] == LVL_ALARM &&
                      CMP_W'(count_r[i]) >= CMP_W'(alarm_hold_r));
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_LEDS; i++) begin
      shown_nxt[i]   = shown_r[i];
      running_nxt[i] = running_r[i];
      count_nxt[i]   = count_r[i];
      changed[i]     = 1'b0;
      if (s3_op_r == OP_TICK) begin
        if (s3_want_r[i] > shown_r[i]) begin
          // A rise shows at once and restarts the hold.
          shown_nxt[i]   = s3_want_r[i];
          running_nxt[i] = 1'b1;
          count_nxt[i]   = '0;
          changed[i]     = 1'b1;
        end else if (s3_want_r[i] == shown_r[i]) begin
          if (running_r[i]) begin
            count_nxt[i] = count_sat[i];
          end
        end else if (expired[i]) begin
          // A fall after the hold; an alarm falling to concern keeps its count.
          shown_nxt[i] = s3_want_r[i];
          changed[i]   = 1'b1;
          if (s3_want_r[i] == LVL_IDLE) begin
            running_nxt[i] = 1'b0;
            count_nxt[i]   = '0;
          end
        end else begin
          count_nxt[i] = count_sat[i];
        end
      end
    end
  end

  // Message list: for a tick, changes in LED order, then the reinforcement round; for a refresh, all levels.
  always_comb begin
    nmsg = '0;
    for (int k = 0; k < MAX_MSG; k++) begin
      msgs[k] = '0;
    end
    if (s3_op_r == OP_REFRESH) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        msgs[nmsg] = '{led_index: LED_IDX_W'(i), level: shown_r[i], notify: 1'b1};
        nmsg       = nmsg + CNT_W'(1);
      end
    end else begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        if (changed[i]) begin
          msgs[nmsg] = '{led_index: LED_IDX_W'(i), level: shown_nxt[i], notify: 1'b1};
          nmsg       = nmsg + CNT_W'(1);
        end
      end
      if (s3_reinf_r) begin
        for (int i = 0; i < NUM_LEDS; i++) begin
          msgs[nmsg] = '{led_index: LED_IDX_W'(i), level: shown_nxt[i], notify: 1'b0};
          nmsg       = nmsg + CNT_W'(1);
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      concern_hold_r <= CFG_W'(5);
      alarm_hold_r   <= CFG_W'(10);
      s1_valid_r     <= 1'b0;
      s2_valid_r     <= 1'b0;
      s3_valid_r     <= 1'b0;
      buf_cnt_r      <= '0;
      out_tvalid_r   <= 1'b0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        shown_r[i]   <= LVL_IDLE;
        running_r[i] <= 1'b0;
        count_r[i]   <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_CONCERN_HOLD: concern_hold_r <= cfg_data;
          CFG_ALARM_HOLD:   alarm_hold_r   <= cfg_data;
          default: ;
        endcase
      end
      if (s1_ready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_ready) begin
        s3_valid_r <= s2_valid_r;
      end
      if (s3_adv) begin
        for (int i = 0; i < NUM_LEDS; i++) begin
          shown_r[i]   <= shown_nxt[i];
          running_r[i] <= running_nxt[i];
          count_r[i]   <= count_nxt[i];
        end
      end
      if (s3_adv && nmsg != '0) begin
        buf_cnt_r <= nmsg;
      end else if (buf_emit) begin
        buf_cnt_r <= buf_cnt_r - CNT_W'(1);
      end
      if (buf_emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tvalid && s1_ready) begin
      s1_op_r   <= in_tuser;
      s1_secs_r <= in_tdata[SECONDS_W-1:0];
      for (int z = 0; z < NUM_ZONES; z++) begin
        s1_zone_r[z] <= in_tdata[SECONDS_W + ZONE_W * z +: ZONE_W];
      end
    end
    if (s2_ready) begin
      s2_op_r   <= s1_op_r;
      s2_secs_r <= s1_secs_r;
      s2_quot_r <= s1_prod[PROD_W-1:SECONDS_W];
      for (int i = 0; i < NUM_LEDS; i++) begin
        s2_want_r[i] <= s1_want[i];
      end
    end
    if (s3_ready) begin
      s3_op_r    <= s2_op_r;
      s3_reinf_r <= s2_reinf;
      for (int i = 0; i < NUM_LEDS; i++) begin
        s3_want_r[i] <= s2_want_r[i];
      end
    end
    if (s3_adv && nmsg != '0) begin
      for (int k = 0; k < MAX_MSG; k++) begin
        buf_msg_r[k] <= msgs[k];
      end
    end else if (buf_emit) begin
      for (int k = 0; k < MAX_MSG - 1; k++) begin
        buf_msg_r[k] <= buf_msg_r[k + 1];
      end
    end
    if (buf_emit) begin
      out_msg_r  <= buf_msg_r[0];
      out_last_r <= (buf_cnt_r == CNT_W'(1));
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_DATA_W'({out_msg_r.level, out_msg_r.led_index});
  assign out_tuser  = out_msg_r.notify;
  assign out_tlast  = out_last_r;

  // An idle LED never has a hold running or a count left over.
  for (genvar g = 0; g < NUM_LEDS; g++) begin : g_idle_chk
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
      shown_r[g] == LVL_IDLE |-> !running_r[g] && count_r[g] == '0)
      else $error("idle LED with a running hold");
  end

  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    buf_cnt_r <= CNT_W'(MAX_MSG))
    else $error("message buffer count out of range");

  // An item waiting on a busy buffer keeps its contents.
  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r && !buf_free |=> s3_valid_r && $stable(s3_op_r) && $stable(s3_reinf_r))
    else $error("stage 3 item changed while stalled");

endmodule
